// ----- rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scancode key FIFO: operation codes,
// the result record and the set-1 scancode to ASCII translation table.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam logic [1:0] OP_SCAN = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [7:0] BREAK_MASK = 8'h80;
    localparam logic [7:0] FILL_MAX   = 8'hFF;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_char;
        logic       key_stored;
        logic [7:0] echo_char;
        logic       dropped;
        logic [7:0] fill_level;
    } t_skf_res;

    localparam logic [7:0] SET1_TABLE [128] = '{
        1: 8'h1B,  2: 8'h31,  3: 8'h32,  4: 8'h33,  5: 8'h34,  6: 8'h35,
        7: 8'h36,  8: 8'h37,  9: 8'h38, 10: 8'h39, 11: 8'h30, 12: 8'h2D,
        13: 8'h3D, 14: 8'h08, 15: 8'h09, 16: 8'h71, 17: 8'h77, 18: 8'h65,
        19: 8'h72, 20: 8'h74, 21: 8'h79, 22: 8'h75, 23: 8'h69, 24: 8'h6F,
        25: 8'h70, 26: 8'h5B, 27: 8'h5D, 28: 8'h0A, 30: 8'h61, 31: 8'h73,
        32: 8'h64, 33: 8'h66, 34: 8'h67, 35: 8'h68, 36: 8'h6A, 37: 8'h6B,
        38: 8'h6C, 39: 8'h3B, 40: 8'h27, 41: 8'h60, 43: 8'h5C, 44: 8'h7A,
        45: 8'h78, 46: 8'h63, 47: 8'h76, 48: 8'h62, 49: 8'h6E, 50: 8'h6D,
        51: 8'h2C, 52: 8'h2E, 53: 8'h2F, 55: 8'h2A, 57: 8'h20,
        default: 8'h00
    };

endpackage

// ----- rtl/skf_if.sv -----
// ----------------------------------------------------------------------------
// skf_in_if / skf_out_if
// Valid/ready channels carrying operations into the key FIFO and results
// out of it.
// ----------------------------------------------------------------------------
interface skf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] scancode;
    logic [7:0] key_char;

    modport source (output valid, output op, output scancode, output key_char, input ready);
    modport sink   (input valid, input op, input scancode, input key_char, output ready);
endinterface

interface skf_out_if;
    logic       valid;
    logic       ready;
    logic       read_valid;
    logic [7:0] read_char;
    logic       key_stored;
    logic [7:0] echo_char;
    logic       dropped;
    logic [7:0] fill_level;

    modport source (output valid, output read_valid, output read_char, output key_stored,
                    output echo_char, output dropped, output fill_level, input ready);
    modport sink   (input valid, input read_valid, input read_char, input key_stored,
                    input echo_char, input dropped, input fill_level, output ready);
endinterface

// ----- rtl/skf_ram.sv -----
// ----------------------------------------------------------------------------
// skf_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module skf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/scancode_key_fifo.sv -----
// ----------------------------------------------------------------------------
// scancode_key_fifo
// Keyboard character ring buffer with set-1 scancode translation, direct
// character pushes and non-blocking reads of the oldest character.
// ----------------------------------------------------------------------------
// Pipeline: each accepted transaction passes through r_s1, then r_out.
// Throughput: one transaction per cycle unless stalled; the pointers and
// count live in registers and the character store takes one write and one
// read per cycle. Reset: synchronous active-low reset empties the ring and
// the pipeline; the character store itself is not cleared.
module scancode_key_fifo #(
    parameter int RING_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    skf_in_if.sink    i_key,
    skf_out_if.source o_res
);
    import skf_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW-1:0] r_count, n_count;
    logic          r_s1_valid;
    t_skf_res      r_s1;
    logic          r_out_valid;
    t_skf_res      r_out;

    logic          w_accept;
    logic [7:0]    w_char;
    logic          w_full;
    logic          w_push;
    logic          w_drop;
    logic          w_pop;
    logic          w_s1_adv;
    logic [AW+7:0] w_count_ext;
    t_skf_res      w_s1_next;
    t_skf_res      w_out_next;
    logic [7:0]    w_rdata;

    assign w_s1_adv    = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_key.ready = !r_s1_valid || w_s1_adv;
    assign w_accept    = i_key.valid && i_key.ready;

    always_comb begin
        case (i_key.op)
            OP_SCAN: w_char = ((i_key.scancode & BREAK_MASK) != 8'h00) ? 8'h00
                              : SET1_TABLE[i_key.scancode[6:0]];
            OP_PUSH: w_char = i_key.key_char;
            default: w_char = 8'h00;
        endcase
    end

    assign w_full = (r_count == LAST);
    assign w_push = w_accept && (w_char != 8'h00) && !w_full;
    assign w_drop = w_accept && (w_char != 8'h00) && w_full;
    assign w_pop  = w_accept && (i_key.op == OP_READ) && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr  = (r_wptr == LAST) ? '0 : r_wptr + AW'(1);
            n_count = r_count + AW'(1);
        end
        if (w_pop) begin
            n_rptr  = (r_rptr == LAST) ? '0 : r_rptr + AW'(1);
            n_count = r_count - AW'(1);
        end
    end

    assign w_count_ext = {8'h00, n_count};

    always_comb begin
        w_s1_next            = '0;
        w_s1_next.read_valid = w_pop;
        w_s1_next.key_stored = w_push;
        w_s1_next.echo_char  = w_push ? w_char : 8'h00;
        w_s1_next.dropped    = w_drop;
        w_s1_next.fill_level = (w_count_ext > (AW + 8)'(FILL_MAX)) ? FILL_MAX
                               : w_count_ext[7:0];
    end

    skf_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_wptr),
        .i_wdata (w_char),
        .i_re    (w_pop),
        .i_raddr (r_rptr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_out_next           = r_s1;
        w_out_next.read_char = r_s1.read_valid ? w_rdata : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_s1 <= w_s1_next;
        end
        if (w_s1_adv) begin
            r_out <= w_out_next;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.read_valid = r_out.read_valid;
    assign o_res.read_char  = r_out.read_char;
    assign o_res.key_stored = r_out.key_stored;
    assign o_res.echo_char  = r_out.echo_char;
    assign o_res.dropped    = r_out.dropped;
    assign o_res.fill_level = r_out.fill_level;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST)
        else $error("Character count exceeds ring capacity.");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("Empty ring with unequal pointers.");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_res.ready) |-> !i_key.ready)
        else $error("Transaction accepted while the pipeline is stalled.");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.read_valid && (o_res.key_stored || o_res.dropped)))
        else $error("Result mixes a read with a push outcome.");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> r_s1_valid && r_s1.read_valid)
        else $error("Pop lost before the read data stage.");

endmodule

// ----- sim/tb_scancode_key_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_key_fifo
// Self-checking bench for the scancode key FIFO. A short table of operations
// covers the empty ring, the unused opcode, break codes, zero characters and
// the edges of the translation table. It is followed by random traffic that
// fills the ring until keys are dropped and then drains it again. Every
// result is compared field by field with the row's own expectation for typed
// rows and with a ring model kept in the bench otherwise, while both channels
// idle at random and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_scancode_key_fifo;
    import skf_pkg::*;

    localparam int RING_DEPTH      = 256;
    localparam int RANDOM_OPS      = 800;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] SCAN_ASCII [59] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] scancode;
        logic [7:0] key_char;
        logic       typed;
        t_skf_res   want;
    } t_key_row;

    localparam t_skf_res NO_EFFECT = '0;

    localparam t_key_row DIRECTED_ROWS [24] = '{
        '{OP_READ,   8'h00, 8'h00, 1'b1, NO_EFFECT},
        '{OP_UNUSED, 8'hFF, 8'hFF, 1'b1, NO_EFFECT},
        '{OP_SCAN,   8'h00, 8'hA5, 1'b1, NO_EFFECT},
        '{OP_SCAN,   8'h81, 8'h00, 1'b1, NO_EFFECT},
        '{OP_SCAN,   8'hFF, 8'hFF, 1'b1, NO_EFFECT},
        '{OP_SCAN,   8'h7F, 8'h00, 1'b1, NO_EFFECT},
        '{OP_PUSH,   8'h3C, 8'h00, 1'b1, NO_EFFECT},
        '{OP_SCAN,   8'h01, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b1, 8'h1B, 1'b0, 8'd1}},
        '{OP_PUSH,   8'h00, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b1, 8'hFF, 1'b0, 8'd2}},
        '{OP_PUSH,   8'h00, 8'h01, 1'b0, NO_EFFECT},
        '{OP_SCAN,   8'h1C, 8'h00, 1'b0, NO_EFFECT},
        '{OP_SCAN,   8'h0E, 8'h00, 1'b0, NO_EFFECT},
        '{OP_SCAN,   8'h0F, 8'h00, 1'b0, NO_EFFECT},
        '{OP_SCAN,   8'h39, 8'h00, 1'b0, NO_EFFECT},
        '{OP_SCAN,   8'h3A, 8'h00, 1'b0, NO_EFFECT},
        '{OP_SCAN,   8'h3B, 8'h00, 1'b0, NO_EFFECT},
        '{OP_READ,   8'h00, 8'h00, 1'b1, '{1'b1, 8'h1B, 1'b0, 8'h00, 1'b0, 8'd6}},
        '{OP_READ,   8'hFF, 8'hFF, 1'b0, NO_EFFECT},
        '{OP_READ,   8'h00, 8'h00, 1'b0, NO_EFFECT},
        '{OP_READ,   8'h00, 8'h00, 1'b0, NO_EFFECT},
        '{OP_READ,   8'h00, 8'h00, 1'b0, NO_EFFECT},
        '{OP_READ,   8'h00, 8'h00, 1'b0, NO_EFFECT},
        '{OP_READ,   8'h00, 8'h00, 1'b0, NO_EFFECT},
        '{OP_READ,   8'h00, 8'h00, 1'b1, NO_EFFECT}
    };

    logic i_clk;
    logic i_rst_n;

    skf_in_if  key_if ();
    skf_out_if res_if ();

    scancode_key_fifo #(
        .RING_DEPTH(RING_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_res   (res_if)
    );

    logic [7:0] ring_chars [RING_DEPTH];
    int         ring_wr;
    int         ring_rd;
    int         ring_count;

    t_skf_res   fifo_results_due [$];

    int send_idle_pct = 24;
    int recv_idle_pct = 77;
    bit hold_off_pending;

    int mismatch_count;
    int ops_sent;
    int stores_seen;
    int drops_seen;
    int pops_seen;
    int max_fill_seen;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic t_skf_res apply_key_op(logic [1:0] op, logic [7:0] sc, logic [7:0] kc);
        t_skf_res   res;
        logic [7:0] ch;
        res = '0;
        ch  = 8'h00;
        if (op == OP_SCAN) begin
            if ((sc & BREAK_MASK) == 8'h00 && sc < 8'd59) begin
                ch = SCAN_ASCII[sc[5:0]];
            end
        end else if (op == OP_PUSH) begin
            ch = kc;
        end
        if ((op == OP_SCAN || op == OP_PUSH) && ch != 8'h00) begin
            if (ring_count >= RING_DEPTH - 1) begin
                res.dropped = 1'b1;
            end else begin
                ring_chars[ring_wr] = ch;
                ring_wr             = (ring_wr + 1) % RING_DEPTH;
                ring_count++;
                res.key_stored = 1'b1;
                res.echo_char  = ch;
            end
        end else if (op == OP_READ && ring_count > 0) begin
            res.read_valid = 1'b1;
            res.read_char  = ring_chars[ring_rd];
            ring_rd        = (ring_rd + 1) % RING_DEPTH;
            ring_count--;
        end
        res.fill_level = (ring_count > 255) ? FILL_MAX : 8'(ring_count);
        return res;
    endfunction

    task automatic offer_key_op(input logic [1:0] op, input logic [7:0] sc,
                                input logic [7:0] kc, input logic typed,
                                input t_skf_res want);
        t_skf_res predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            key_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        key_if.valid    <= 1'b1;
        key_if.op       <= op;
        key_if.scancode <= sc;
        key_if.key_char <= kc;
        @(posedge i_clk);
        while (!key_if.ready) @(posedge i_clk);
        predicted = apply_key_op(op, sc, kc);
        fifo_results_due.push_back(typed ? want : predicted);
        ops_sent++;
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_skf_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (fifo_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         {res_if.read_valid, res_if.read_char, res_if.key_stored,
                          res_if.echo_char, res_if.dropped, res_if.fill_level});
                mismatch_count++;
            end else begin
                want = fifo_results_due.pop_front();
                check_field("read_valid", 8'(want.read_valid), 8'(res_if.read_valid));
                check_field("read_char",  want.read_char,      res_if.read_char);
                check_field("key_stored", 8'(want.key_stored), 8'(res_if.key_stored));
                check_field("echo_char",  want.echo_char,      res_if.echo_char);
                check_field("dropped",    8'(want.dropped),    8'(res_if.dropped));
                check_field("fill_level", want.fill_level,     res_if.fill_level);
                stores_seen += want.key_stored;
                drops_seen  += want.dropped;
                pops_seen   += want.read_valid;
                if (want.fill_level > max_fill_seen) max_fill_seen = want.fill_level;
            end
        end
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        logic [1:0] op;
        logic [7:0] sc;
        logic [7:0] kc;
        int         push_pct;
        int         roll;

        ring_wr    = 0;
        ring_rd    = 0;
        ring_count = 0;
        i_rst_n         <= 1'b0;
        key_if.valid    <= 1'b0;
        key_if.op       <= OP_READ;
        key_if.scancode <= 8'h00;
        key_if.key_char <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            offer_key_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].scancode,
                         DIRECTED_ROWS[i].key_char, DIRECTED_ROWS[i].typed,
                         DIRECTED_ROWS[i].want);
        end

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS / 3) begin
                send_idle_pct = 77;
                recv_idle_pct = 24;
            end else if (n == 2 * RANDOM_OPS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 100) hold_off_pending = 1'b1;

            if (n < 460)      push_pct = 95;
            else if (n < 600) push_pct = 15;
            else if (n < 700) push_pct = 55;
            else              push_pct = 5;

            roll = $urandom_range(0, 99);
            sc   = 8'($urandom_range(0, 255));
            kc   = 8'($urandom_range(0, 255));
            if (roll < push_pct) begin
                if ($urandom_range(0, 2) == 0) begin
                    op = OP_SCAN;
                    if ($urandom_range(0, 9) < 6) sc = 8'($urandom_range(0, 58));
                end else begin
                    op = OP_PUSH;
                end
            end else if (roll < 98) begin
                op = OP_READ;
            end else begin
                op = OP_UNUSED;
            end
            offer_key_op(op, sc, kc, 1'b0, NO_EFFECT);
        end
        key_if.valid <= 1'b0;

        while (fifo_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d operations: %0d keys stored, %0d dropped on a full ring,",
                 ops_sent, stores_seen, drops_seen);
        $display("%0d characters read back, highest fill level %0d.",
                 pops_seen, max_fill_seen);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", fifo_results_due.size());
        $display("simulation failed");
        $finish;
    end

endmodule
